[sv/sync_length_xor_frame_receiver_macros.svh]
// Assertion helpers used by the checker file of the frame receiver.
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_MACROS_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLXFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLXFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/slxfr_pkg.sv]
package slxfr_pkg;

  // Input transaction: one received byte or one time tick.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } slxfr_in_t;

  // Result transaction.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [7:0] frame_length;
    logic       last;
  } slxfr_out_t;

  // Command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Status codes.
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_BYTE = 3'd2;
  localparam logic [2:0] ST_LONG = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_ZERO = 3'd5;

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_IDLE_TMO = 2'd0;
  localparam logic [1:0] REG_BYTE_TMO = 2'd1;
  localparam logic [1:0] REG_MAX_LEN  = 2'd2;

  localparam logic [15:0] IDLE_TMO_RST = 16'd100;
  localparam logic [15:0] BYTE_TMO_RST = 16'd5;
  localparam logic [5:0]  MAX_LEN_RST  = 6'd32;

endpackage

[sv/sync_length_xor_frame_receiver.sv]
// Sync-byte, length-prefixed frame receiver with XOR checksum.
// Input channel (in_valid/in_ready/in_data): each transaction is either one
// received byte or one time tick. The receiver hunts for 0x55, takes a length
// byte L, then L body bytes whose XOR must be zero (the last is the checksum).
// Result channel (out_valid/out_ready/out_data): a good frame gives its L-1
// payload bytes as a run closed by last; any error gives one status result.
// The APB-style port holds the idle timeout, byte timeout and maximum length.
// A byte or tick is accepted when in_valid and in_ready are both high, and any
// single result it causes is registered at that same edge, so it appears in the
// next cycle. After the final byte of a good frame the body is read back from
// the payload RAM: each payload byte is first read from the RAM and then loaded
// into the output register once it is free; no input is taken during that run.
// Input is accepted while the output register is empty or being emptied, so a
// stalled receiver of results holds back the input channel and nothing is lost.
// Reset (synchronous, active low) returns to hunting, empties the output
// register and loads the register defaults 100, 5 and 32. The payload RAM is
// not cleared; only entries written in the current frame are read.
module sync_length_xor_frame_receiver #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  slxfr_pkg::slxfr_in_t        in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output slxfr_pkg::slxfr_out_t       out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slxfr_pkg::CFG_AW-1:0] paddr,
  input  logic [slxfr_pkg::CFG_DW-1:0] pwdata,
  output logic [slxfr_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  localparam int IDX_W = $clog2(BUFFER_BYTES);
  localparam logic [7:0] BUF_LEN = 8'(BUFFER_BYTES);

  typedef enum logic [1:0] {S_RUN, S_DRD, S_DOUT} state_t;
  typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_BODY} phase_t;

  state_t               st_r, st_nxt;
  phase_t               phase_r, phase_nxt;
  logic [7:0]           exp_len_r, exp_len_nxt;
  logic [7:0]           rcv_cnt_r, rcv_cnt_nxt;
  logic [7:0]           xor_r, xor_nxt;
  logic [15:0]          tick_r, tick_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  slxfr_pkg::slxfr_out_t out_data_r, out_data_nxt;

  logic [15:0]          idle_tmo_r;
  logic [15:0]          byte_tmo_r;
  logic [5:0]           max_len_r;

  logic                 ram_we;
  logic                 ram_re;
  logic [7:0]           ram_rdata;

  logic                 cfg_wr;
  logic [1:0]           cfg_idx;
  logic [7:0]           limit;
  logic [15:0]          tick_lim;
  logic [7:0]           rcv_inc;
  logic [7:0]           xor_new;
  logic                 drain_last;
  logic                 slot_free;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      slxfr_pkg::REG_IDLE_TMO: prdata = slxfr_pkg::CFG_DW'(idle_tmo_r);
      slxfr_pkg::REG_BYTE_TMO: prdata = slxfr_pkg::CFG_DW'(byte_tmo_r);
      slxfr_pkg::REG_MAX_LEN:  prdata = slxfr_pkg::CFG_DW'(max_len_r);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_tmo_r <= slxfr_pkg::IDLE_TMO_RST;
      byte_tmo_r <= slxfr_pkg::BYTE_TMO_RST;
      max_len_r  <= slxfr_pkg::MAX_LEN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        slxfr_pkg::REG_IDLE_TMO: idle_tmo_r <= pwdata[15:0];
        slxfr_pkg::REG_BYTE_TMO: byte_tmo_r <= pwdata[15:0];
        slxfr_pkg::REG_MAX_LEN:  max_len_r  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Payload store. Drain reads only happen while input is blocked, so a
  // read never meets a write to the same entry.
  slxfr_ram #(
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rcv_cnt_r[IDX_W-1:0]),
    .wdata (in_data.data_byte),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Shared derived values.
  assign limit      = (8'(max_len_r) < BUF_LEN) ? 8'(max_len_r) : BUF_LEN;
  assign tick_lim   = (phase_r == PH_HUNT) ? idle_tmo_r : byte_tmo_r;
  assign rcv_inc    = rcv_cnt_r + 8'd1;
  assign xor_new    = xor_r ^ in_data.data_byte;
  assign drain_last = (8'(idx_r) + 8'd2) == exp_len_r;
  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (st_r == S_RUN) && slot_free;

  // Next-state logic for the frame state and the output register.
  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    exp_len_nxt   = exp_len_r;
    rcv_cnt_nxt   = rcv_cnt_r;
    xor_nxt       = xor_r;
    tick_nxt      = tick_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    unique case (st_r)
      S_RUN: begin
        if (in_valid && in_ready) begin
          out_data_nxt.status       = slxfr_pkg::ST_OK;
          out_data_nxt.payload_byte = 8'd0;
          out_data_nxt.byte_valid   = 1'b0;
          out_data_nxt.frame_length = 8'd0;
          out_data_nxt.last         = 1'b1;
          if (in_data.cmd == slxfr_pkg::CMD_TICK) begin
            // Tick: count up, or time out once the limit is reached.
            if (tick_r < tick_lim) begin
              tick_nxt = tick_r + 16'd1;
            end else begin
              tick_nxt      = 16'd0;
              out_valid_nxt = 1'b1;
              if (phase_r == PH_HUNT) begin
                out_data_nxt.status = slxfr_pkg::ST_IDLE;
              end else begin
                out_data_nxt.status = slxfr_pkg::ST_BYTE;
                if (phase_r == PH_BODY) begin
                  out_data_nxt.frame_length = exp_len_r;
                end
                phase_nxt = PH_HUNT;
              end
            end
          end else begin
            tick_nxt = 16'd0;
            unique case (phase_r)
              PH_HUNT: begin
                if (in_data.data_byte == slxfr_pkg::SYNC_BYTE) begin
                  phase_nxt = PH_LEN;
                end
              end
              PH_LEN: begin
                if (in_data.data_byte == 8'd0) begin
                  out_valid_nxt       = 1'b1;
                  out_data_nxt.status = slxfr_pkg::ST_ZERO;
                  phase_nxt           = PH_HUNT;
                end else begin
                  exp_len_nxt = in_data.data_byte;
                  rcv_cnt_nxt = 8'd0;
                  xor_nxt     = 8'd0;
                  phase_nxt   = PH_BODY;
                end
              end
              default: begin
                // Body byte: store while there is room, then judge at the end.
                ram_we      = rcv_cnt_r < BUF_LEN;
                xor_nxt     = xor_new;
                rcv_cnt_nxt = rcv_inc;
                if (rcv_inc >= exp_len_r) begin
                  phase_nxt                 = PH_HUNT;
                  out_data_nxt.frame_length = exp_len_r;
                  if (exp_len_r > limit) begin
                    out_valid_nxt       = 1'b1;
                    out_data_nxt.status = slxfr_pkg::ST_LONG;
                  end else if (xor_new != 8'd0) begin
                    out_valid_nxt       = 1'b1;
                    out_data_nxt.status = slxfr_pkg::ST_SUM;
                  end else if (exp_len_r == 8'd1) begin
                    out_valid_nxt = 1'b1;
                  end else begin
                    idx_nxt = '0;
                    st_nxt  = S_DRD;
                  end
                end
              end
            endcase
          end
        end
      end
      S_DRD: begin
        ram_re = 1'b1;
        st_nxt = S_DOUT;
      end
      S_DOUT: begin
        // Load one payload byte once the output register is free.
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = slxfr_pkg::ST_OK;
          out_data_nxt.payload_byte = ram_rdata;
          out_data_nxt.byte_valid   = 1'b1;
          out_data_nxt.frame_length = exp_len_r;
          out_data_nxt.last         = drain_last;
          if (drain_last) begin
            st_nxt = S_RUN;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            st_nxt  = S_DRD;
          end
        end
      end
      default: begin
        st_nxt = S_RUN;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_RUN;
      phase_r     <= PH_HUNT;
      exp_len_r   <= 8'd0;
      rcv_cnt_r   <= 8'd0;
      xor_r       <= 8'd0;
      tick_r      <= 16'd0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      exp_len_r   <= exp_len_nxt;
      rcv_cnt_r   <= rcv_cnt_nxt;
      xor_r       <= xor_nxt;
      tick_r      <= tick_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/slxfr_ram.sv]
module slxfr_ram #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/slxfr_chk.sv]
`include "sync_length_xor_frame_receiver_macros.svh"

module slxfr_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input slxfr_pkg::slxfr_out_t out_data
);

  // A stalled result transaction holds.
  `SLXFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Status stays within its defined codes.
  `SLXFR_ASSERT_NOW(a_status_range, clk, rst_n, out_valid, out_data.status <= slxfr_pkg::ST_ZERO, "undefined status code")

  // A payload byte only comes from a good frame of at least two bytes.
  `SLXFR_ASSERT_NOW(a_payload_ok, clk, rst_n, out_valid && out_data.byte_valid, (out_data.status == slxfr_pkg::ST_OK) && (out_data.frame_length >= 8'd2), "payload byte outside a good frame")

  // Error results and the checksum-only frame are single, empty results.
  `SLXFR_ASSERT_NOW(a_single_result, clk, rst_n, out_valid && !out_data.byte_valid, out_data.last && (out_data.payload_byte == 8'd0) && ((out_data.status != slxfr_pkg::ST_OK) || (out_data.frame_length == 8'd1)), "malformed single result")

endmodule

bind sync_length_xor_frame_receiver slxfr_chk u_slxfr_chk (.*);
